### hw/rtl/hnt_pkg.sv
// Shared types, constants and small index tables for the node transform block.
package hnt_pkg;

   localparam int MAX_NODES_DEF = 256;
   localparam int FRAC_BITS_DEF = 16;
   localparam int REQ_DATA_W    = 336;
   localparam int RSP_DATA_W    = 144;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_QMUL,
      ST_QDRAIN,
      ST_RBUILD,
      ST_LMUL,
      ST_LDRAIN,
      ST_GMUL,
      ST_GDRAIN,
      ST_STORE,
      ST_EMIT
   } state_type;

   // What a multiplier operation feeds at write back.
   typedef enum logic [1:0] {
      OP_QUAT,
      OP_LOCAL,
      OP_GLOBAL
   } op_kind_type;

   // Tag carried down the multiplier pipeline.
   typedef struct packed {
      logic        valid;
      op_kind_type kind;
      logic [5:0]  tag;
   } op_tag_type;

   // Saturate a wide signed value to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      logic signed [31:0] r;
      if (v > 68'sh0_0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -68'sh0_0000_0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Quaternion product order: xx yy zz xy xz yz xw yw zw (x=0 y=1 z=2 w=3).
   function automatic logic [1:0] quat_a_sel(input logic [3:0] n);
      logic [1:0] r;
      unique case (n)
         4'd0, 4'd3, 4'd4, 4'd6: r = 2'd0;
         4'd1, 4'd5, 4'd7:       r = 2'd1;
         default:                r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] quat_b_sel(input logic [3:0] n);
      logic [1:0] r;
      unique case (n)
         4'd0:                   r = 2'd0;
         4'd1, 4'd3:             r = 2'd1;
         4'd2, 4'd4, 4'd5:       r = 2'd2;
         default:                r = 2'd3;
      endcase
      return r;
   endfunction

   // Rotation element n (row-major 3x3) maps to local matrix entry row*4+col.
   function automatic logic [3:0] local_dest(input logic [3:0] n);
      logic [3:0] r;
      unique case (n)
         4'd0: r = 4'd0;
         4'd1: r = 4'd1;
         4'd2: r = 4'd2;
         4'd3: r = 4'd4;
         4'd4: r = 4'd5;
         4'd5: r = 4'd6;
         4'd6: r = 4'd8;
         4'd7: r = 4'd9;
         default: r = 4'd10;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] local_row(input logic [3:0] n);
      logic [1:0] r;
      unique case (n)
         4'd0, 4'd1, 4'd2: r = 2'd0;
         4'd3, 4'd4, 4'd5: r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

endpackage

### hw/rtl/hierarchical_node_transform_top.sv
// Scale/rotate/translate hierarchy transform on one shared multiplier.
// Each node is accepted while idle, computed, then returned as eight results; a node past
// capacity stores nothing, and only a node with a valid parent runs the parent product.
// A new node is taken only when idle, after all eight results of the last node have left.
// The single 32x32 multiplier computes 18 products per node, plus 64 for the parent product.
// Reset is synchronous, active high; it clears the sequencer and the node counter.
module hierarchical_node_transform_top #(
   parameter int MAX_NODES = hnt_pkg::MAX_NODES_DEF,
   parameter int FRAC_BITS = hnt_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // parent_index, scale_x/y/z, quat_x/y/z/w, trans_x/y/z, zero pad
   input  logic [hnt_pkg::REQ_DATA_W-1:0] req_tdata,
   // first_node
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // node_number, row_number, elem_0..elem_3, zero pad
   output logic [hnt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // which_matrix, node_error
   output logic [1:0]                     rsp_tuser,
   // last_row
   output logic                           rsp_tlast
);

   localparam int NW  = $clog2(MAX_NODES + 1);
   localparam int PW  = $clog2(MAX_NODES);
   localparam int AW  = PW + 4;
   localparam int MEM_DEPTH = MAX_NODES * 16;
   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

   hnt_pkg::state_type state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [NW-1:0] node_ctr_ff;
   logic [NW-1:0] node_ff;
   logic [7:0]  par_ff;
   logic        over_ff, valid_par_ff, err_ff;

   logic signed [31:0] q_ff [4];
   logic signed [31:0] s_ff [3];
   logic signed [31:0] qp_ff [9];
   logic signed [31:0] r_ff [9];
   logic signed [31:0] l_ff [16];
   logic signed [31:0] g_ff [16];
   logic signed [33:0] acc_ff;
   logic [31:0] mem [MEM_DEPTH];
   logic signed [31:0] mem_q_ff;

   // Multiplier pipeline.
   hnt_pkg::op_tag_type iss, t1_ff, t2_ff;
   logic signed [31:0] iss_a, iss_b, a_ff, b_ff;
   logic signed [63:0] prod_ff;
   logic [AW-1:0] rd_addr;
   logic copy_g, accept, node_over, node_vpar;
   logic [NW-1:0] node_now;
   logic signed [8:0] par_in;

   assign accept = req_tvalid && req_tready;
   assign par_in = req_tdata[8:0];
   assign node_now = req_tuser ? '0 : node_ctr_ff;
   assign node_over = (32'(node_now) >= 32'(MAX_NODES));
   assign node_vpar = !node_over && !par_in[8] && (32'(par_in[7:0]) < 32'(node_now));

   // Sequencer next state and operation issue.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      iss      = '{valid: 1'b0, kind: hnt_pkg::OP_QUAT, tag: cnt_ff};
      iss_a    = q_ff[hnt_pkg::quat_a_sel(cnt_ff[3:0])];
      iss_b    = q_ff[hnt_pkg::quat_b_sel(cnt_ff[3:0])];
      rd_addr  = (AW'(par_ff) << 4) | AW'({cnt_ff[1:0], cnt_ff[3:2]});
      copy_g   = 1'b0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         hnt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cnt_in = '0;
            if (req_tvalid) begin
               state_in = hnt_pkg::ST_QMUL;
            end
         end
         hnt_pkg::ST_QMUL: begin
            iss.valid = 1'b1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd8) begin
               state_in = hnt_pkg::ST_QDRAIN;
            end
         end
         hnt_pkg::ST_QDRAIN: begin
            if (!t1_ff.valid && !t2_ff.valid) begin
               state_in = hnt_pkg::ST_RBUILD;
            end
         end
         hnt_pkg::ST_RBUILD: begin
            cnt_in = '0;
            state_in = hnt_pkg::ST_LMUL;
         end
         hnt_pkg::ST_LMUL: begin
            iss = '{valid: 1'b1, kind: hnt_pkg::OP_LOCAL,
                    tag: {2'b00, hnt_pkg::local_dest(cnt_ff[3:0])}};
            iss_a = s_ff[hnt_pkg::local_row(cnt_ff[3:0])];
            iss_b = r_ff[cnt_ff[3:0]];
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd8) begin
               state_in = hnt_pkg::ST_LDRAIN;
            end
         end
         hnt_pkg::ST_LDRAIN: begin
            cnt_in = '0;
            if (!t1_ff.valid && !t2_ff.valid) begin
               if (valid_par_ff) begin
                  state_in = hnt_pkg::ST_GMUL;
               end else begin
                  copy_g = 1'b1;
                  state_in = over_ff ? hnt_pkg::ST_EMIT : hnt_pkg::ST_STORE;
               end
            end
         end
         hnt_pkg::ST_GMUL: begin
            // Tag bits: row [5:4], column [3:2], inner index [1:0].
            iss = '{valid: 1'b1, kind: hnt_pkg::OP_GLOBAL, tag: cnt_ff};
            iss_a = l_ff[{cnt_ff[5:4], cnt_ff[1:0]}];
            iss_b = '0;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = hnt_pkg::ST_GDRAIN;
            end
         end
         hnt_pkg::ST_GDRAIN: begin
            cnt_in = '0;
            if (!t1_ff.valid && !t2_ff.valid) begin
               state_in = over_ff ? hnt_pkg::ST_EMIT : hnt_pkg::ST_STORE;
            end
         end
         hnt_pkg::ST_STORE: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff[3:0] == 4'd15) begin
               cnt_in = '0;
               state_in = hnt_pkg::ST_EMIT;
            end
         end
         hnt_pkg::ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff[2:0] == 3'd7) begin
                  cnt_in = '0;
                  state_in = hnt_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = hnt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hnt_pkg::ST_IDLE;
         cnt_ff   <= '0;
         t1_ff    <= '0;
         t2_ff    <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         t1_ff    <= iss;
         t2_ff    <= t1_ff;
      end
   end

   // Node counter: restarts on the first node, stops at capacity.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_ctr_ff <= '0;
      end else if (accept) begin
         node_ctr_ff <= node_now + (node_over ? NW'(0) : NW'(1));
      end
   end

   // Capture of the item.
   always_ff @(posedge clock) begin
      if (accept) begin
         node_ff      <= node_now;
         par_ff       <= par_in[7:0];
         over_ff      <= node_over;
         valid_par_ff <= node_vpar;
         err_ff       <= node_over || (par_in != -9'sd1 && !node_vpar);
         s_ff[0] <= req_tdata[40:9];
         s_ff[1] <= req_tdata[72:41];
         s_ff[2] <= req_tdata[104:73];
         q_ff[0] <= req_tdata[136:105];
         q_ff[1] <= req_tdata[168:137];
         q_ff[2] <= req_tdata[200:169];
         q_ff[3] <= req_tdata[232:201];
      end
   end

   // Shared multiplier: operand stage, then product stage.
   always_ff @(posedge clock) begin
      a_ff    <= iss_a;
      b_ff    <= iss_b;
      prod_ff <= a_ff * ((t1_ff.kind == hnt_pkg::OP_GLOBAL) ? mem_q_ff : b_ff);
   end

   // Rounding, floor shift and saturation of the product.
   logic signed [64:0] rnd_sum, rnd_shf;
   logic signed [31:0] qres;
   logic signed [33:0] acc_sum;
   assign rnd_sum = {prod_ff[63], prod_ff} + (65'sd1 <<< (FRAC_BITS - 1));
   assign rnd_shf = rnd_sum >>> FRAC_BITS;
   assign qres    = hnt_pkg::sat32({{3{rnd_shf[64]}}, rnd_shf});
   assign acc_sum = ((t2_ff.tag[1:0] == 2'd0) ? 34'sd0 : acc_ff)
                    + {{2{qres[31]}}, qres};

   // Write back of finished products; the local entries that need no product load at accept.
   always_ff @(posedge clock) begin
      if (t2_ff.valid) begin
         unique case (t2_ff.kind)
            hnt_pkg::OP_QUAT: qp_ff[t2_ff.tag[3:0]] <= qres;
            hnt_pkg::OP_LOCAL: l_ff[t2_ff.tag[3:0]] <= qres;
            hnt_pkg::OP_GLOBAL: begin
               acc_ff <= acc_sum;
               if (t2_ff.tag[1:0] == 2'd3) begin
                  g_ff[t2_ff.tag[5:2]] <= hnt_pkg::sat32({{34{acc_sum[33]}}, acc_sum});
               end
            end
            default: acc_ff <= acc_ff;
         endcase
      end else if (copy_g) begin
         g_ff <= l_ff;
      end else if (accept) begin
         l_ff[3]  <= '0;
         l_ff[7]  <= '0;
         l_ff[11] <= '0;
         l_ff[12] <= req_tdata[264:233];
         l_ff[13] <= req_tdata[296:265];
         l_ff[14] <= req_tdata[328:297];
         l_ff[15] <= ONE;
      end
   end

   // Rotation matrix from the quaternion products.
   logic signed [35:0] d_xx, d_yy, d_zz, d_xy, d_xz, d_yz, d_xw, d_yw, d_zw, one36;
   assign d_xx  = {{3{qp_ff[0][31]}}, qp_ff[0], 1'b0};
   assign d_yy  = {{3{qp_ff[1][31]}}, qp_ff[1], 1'b0};
   assign d_zz  = {{3{qp_ff[2][31]}}, qp_ff[2], 1'b0};
   assign d_xy  = {{3{qp_ff[3][31]}}, qp_ff[3], 1'b0};
   assign d_xz  = {{3{qp_ff[4][31]}}, qp_ff[4], 1'b0};
   assign d_yz  = {{3{qp_ff[5][31]}}, qp_ff[5], 1'b0};
   assign d_xw  = {{3{qp_ff[6][31]}}, qp_ff[6], 1'b0};
   assign d_yw  = {{3{qp_ff[7][31]}}, qp_ff[7], 1'b0};
   assign d_zw  = {{3{qp_ff[8][31]}}, qp_ff[8], 1'b0};
   assign one36 = 36'(ONE);

   always_ff @(posedge clock) begin
      if (state_ff == hnt_pkg::ST_RBUILD) begin
         r_ff[0] <= hnt_pkg::sat32(68'(one36 - d_yy - d_zz));
         r_ff[1] <= hnt_pkg::sat32(68'(d_xy + d_zw));
         r_ff[2] <= hnt_pkg::sat32(68'(d_xz - d_yw));
         r_ff[3] <= hnt_pkg::sat32(68'(d_xy - d_zw));
         r_ff[4] <= hnt_pkg::sat32(68'(one36 - d_xx - d_zz));
         r_ff[5] <= hnt_pkg::sat32(68'(d_yz + d_xw));
         r_ff[6] <= hnt_pkg::sat32(68'(d_xz + d_yw));
         r_ff[7] <= hnt_pkg::sat32(68'(d_yz - d_xw));
         r_ff[8] <= hnt_pkg::sat32(68'(one36 - d_xx - d_yy));
      end
   end

   // Global matrix store: parent read in the product phase, write in the store phase.
   always_ff @(posedge clock) begin
      if (state_ff == hnt_pkg::ST_STORE) begin
         mem[(AW'(node_ff) << 4) | AW'(cnt_ff[3:0])] <= g_ff[cnt_ff[3:0]];
      end
      mem_q_ff <= mem[rd_addr];
   end

   // Result rows: local rows first, then global rows.
   logic [3:0] ebase;
   logic emit_glob;
   assign emit_glob = cnt_ff[2];
   assign ebase = {cnt_ff[1:0], 2'b00};
   assign rsp_tdata = {6'b0,
      emit_glob ? g_ff[ebase | 4'd3] : l_ff[ebase | 4'd3],
      emit_glob ? g_ff[ebase | 4'd2] : l_ff[ebase | 4'd2],
      emit_glob ? g_ff[ebase | 4'd1] : l_ff[ebase | 4'd1],
      emit_glob ? g_ff[ebase]        : l_ff[ebase],
      cnt_ff[1:0], 8'(node_ff)};
   assign rsp_tuser = {err_ff, emit_glob};
   assign rsp_tlast = (cnt_ff[2:0] == 3'd7);

   // Checks on the sequencer.
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("ready while results pending");
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("block not idle after last row");
   a_ctr_cap: assert property (@(posedge clock) disable iff (reset)
      32'(node_ctr_ff) <= 32'(MAX_NODES)) else $error("node counter past capacity");
   a_pipe_idle: assert property (@(posedge clock) disable iff (reset)
      t2_ff.valid |-> (state_ff != hnt_pkg::ST_EMIT && state_ff != hnt_pkg::ST_IDLE))
      else $error("product in flight outside compute phases");

endmodule

### verif/hnt_checker.sv
// Checker for the node transform block: predicts matrix rows and compares results.
`timescale 1ns / 1ps

module hnt_checker #(
   parameter int MAX_NODES = 256,
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [hnt_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [hnt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [1:0]                     rsp_tuser,
   input  logic                           rsp_tlast,
   output int                             fail_count,
   output int                             rows_pending,
   output int                             nodes_seen,
   output int                             error_nodes
);

   // One expected matrix row.
   typedef struct {
      logic               which;
      logic [7:0]         node;
      logic [1:0]         row;
      logic signed [31:0] elem [4];
      logic               last;
      logic               err;
   } matrix_row_type;

   matrix_row_type expected_rows[$];
   int             global_mats [MAX_NODES*16];
   int             position;

   function automatic int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return int'(v);
   endfunction

   // Rounded fixed-point product, floor shift, saturated.
   function automatic int fx_mul(int a, int b);
      longint p;
      p = longint'(a) * longint'(b) + (longint'(1) << (FRAC_BITS - 1));
      return clamp32(p >>> FRAC_BITS);
   endfunction

   task automatic report(input string what, input int got, input int want);
      fail_count++;
      $display("%0t mismatch in %s: got %h, expected %h", $realtime, what, got, want);
   endtask

   // Build local and global matrices of one node and queue their rows.
   task automatic predict_node(input logic [hnt_pkg::REQ_DATA_W-1:0] d, input logic first);
      int               s [3], t [3], q [4], rot [3][3], lm [4][4], gm [4][4];
      int               xx, yy, zz, xy, xz, yz, xw, yw, zw, node;
      longint           one, acc;
      logic signed [8:0] par;
      logic             over, par_ok, err;
      matrix_row_type   r;
      one = longint'(1) << FRAC_BITS;
      par = d[8:0];
      for (int i = 0; i < 3; i++) begin
         s[i] = d[9 + 32*i +: 32];
         t[i] = d[233 + 32*i +: 32];
      end
      for (int i = 0; i < 4; i++) q[i] = d[105 + 32*i +: 32];
      if (first) position = 0;
      node   = position;
      over   = node >= MAX_NODES;
      par_ok = !over && par >= 0 && int'(par) < node;
      err    = over || (par != -1 && !par_ok);

      xx = fx_mul(q[0], q[0]); yy = fx_mul(q[1], q[1]); zz = fx_mul(q[2], q[2]);
      xy = fx_mul(q[0], q[1]); xz = fx_mul(q[0], q[2]); yz = fx_mul(q[1], q[2]);
      xw = fx_mul(q[0], q[3]); yw = fx_mul(q[1], q[3]); zw = fx_mul(q[2], q[3]);
      rot[0][0] = clamp32(one - 2*longint'(yy) - 2*longint'(zz));
      rot[0][1] = clamp32(2*longint'(xy) + 2*longint'(zw));
      rot[0][2] = clamp32(2*longint'(xz) - 2*longint'(yw));
      rot[1][0] = clamp32(2*longint'(xy) - 2*longint'(zw));
      rot[1][1] = clamp32(one - 2*longint'(xx) - 2*longint'(zz));
      rot[1][2] = clamp32(2*longint'(yz) + 2*longint'(xw));
      rot[2][0] = clamp32(2*longint'(xz) + 2*longint'(yw));
      rot[2][1] = clamp32(2*longint'(yz) - 2*longint'(xw));
      rot[2][2] = clamp32(one - 2*longint'(xx) - 2*longint'(yy));

      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) lm[i][j] = fx_mul(s[i], rot[i][j]);
         lm[i][3] = 0;
      end
      for (int j = 0; j < 3; j++) lm[3][j] = t[j];
      lm[3][3] = int'(one);

      // Global matrix: local times parent, or local alone for a root or an invalid parent.
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++) begin
            if (par_ok) begin
               acc = 0;
               for (int k = 0; k < 4; k++)
                  acc += fx_mul(lm[i][k], global_mats[int'(par)*16 + k*4 + j]);
               gm[i][j] = clamp32(acc);
            end else begin
               gm[i][j] = lm[i][j];
            end
         end
      if (!over)
         for (int i = 0; i < 16; i++) global_mats[node*16 + i] = gm[i/4][i%4];
      if (position < MAX_NODES) position++;

      for (int k = 0; k < 8; k++) begin
         r.which = k >= 4;
         r.node  = node[7:0];
         r.row   = 2'(k % 4);
         for (int j = 0; j < 4; j++) r.elem[j] = (k < 4) ? lm[k%4][j] : gm[k%4][j];
         r.last  = k == 7;
         r.err   = err;
         expected_rows.push_back(r);
      end
      nodes_seen++;
      if (err) error_nodes++;
   endtask

   // Watch both channels at the rising edge.
   always @(posedge clock) begin
      matrix_row_type e;
      if (reset) begin
         position = 0;
      end else begin
         if (req_tvalid && req_tready) predict_node(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rows.size() == 0) begin
               report("unexpected item", rsp_tdata[31:0], 0);
            end else begin
               e = expected_rows.pop_front();
               if (rsp_tuser[0] != e.which) report("which_matrix", rsp_tuser[0], e.which);
               if (rsp_tdata[7:0] != e.node) report("node_number", rsp_tdata[7:0], e.node);
               if (rsp_tdata[9:8] != e.row) report("row_number", rsp_tdata[9:8], e.row);
               for (int j = 0; j < 4; j++)
                  if (rsp_tdata[10 + 32*j +: 32] !== e.elem[j])
                     report($sformatf("elem_%0d node %0d row %0d", j, e.node, e.row),
                            rsp_tdata[10 + 32*j +: 32], e.elem[j]);
               if (rsp_tlast != e.last) report("last_row", rsp_tlast, e.last);
               if (rsp_tuser[1] != e.err) report("node_error", rsp_tuser[1], e.err);
            end
         end
      end
      rows_pending = expected_rows.size();
   end

   initial begin
      fail_count   = 0;
      nodes_seen   = 0;
      error_nodes  = 0;
      rows_pending = 0;
      position     = 0;
      foreach (global_mats[i]) global_mats[i] = 0;
   end

endmodule

### verif/testbench.sv
// Top of the node transform testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

   localparam int IDLE_LIMIT = 3000;

   typedef struct {
      logic              first;
      logic signed [8:0] par;
      logic [31:0]       s [3];
      logic [31:0]       q [4];
      logic [31:0]       t [3];
   } node_item_type;

   logic                           clock, reset;
   logic                           req_tvalid, req_tready, req_tuser;
   logic [hnt_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                           rsp_tvalid, rsp_tready, rsp_tlast;
   logic [hnt_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]                     rsp_tuser;
   int                             fail_count, rows_pending, nodes_seen, error_nodes;
   int                             next_position, burst_left, idle_cycles, sent;
   int                             stall_cycle = 0;

   hierarchical_node_transform_top u_top (.*);

   hnt_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Receiver stall pattern: switches in turn among always ready, random, fixed and coin-flip styles.
   always @(negedge clock) begin
      logic [7:0] pat;
      pat = 8'b1011_0110;
      case ((stall_cycle / 64) % 4)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom % 4) != 0;
         2: rsp_tready <= pat[stall_cycle % 8];
         default: rsp_tready <= 1'($urandom % 2);
      endcase
      stall_cycle++;
   end

   // Watchdog on cycles with nothing accepted on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [31:0] rand_value(bit unit_range);
      case ($urandom % 6)
         0: return $urandom;
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         3: return unit_range ? 32'h0001_0000 : 32'h0000_0000;
         default: return unit_range ? $urandom_range(131072) - 65536
                                    : $urandom_range(1 << 20) - (1 << 19);
      endcase
   endfunction

   function automatic node_item_type rand_node(bit first, int broken_pct);
      node_item_type n;
      int            pos;
      n.first = first;
      pos = first ? 0 : next_position;
      for (int i = 0; i < 3; i++) begin
         n.s[i] = rand_value(1);
         n.t[i] = rand_value(0);
      end
      for (int i = 0; i < 4; i++) n.q[i] = rand_value(1);
      if ($urandom_range(99) < broken_pct)
         n.par = 9'($urandom);
      else if (pos == 0 || $urandom % 5 == 0)
         n.par = -1;
      else
         n.par = 9'($urandom_range(pos - 1));
      return n;
   endfunction

   function automatic node_item_type plain_node(bit first, int par, logic [31:0] sv,
                                                logic [31:0] qv, logic [31:0] tv);
      node_item_type n;
      n.first = first;
      n.par   = 9'(par);
      foreach (n.s[i]) n.s[i] = sv;
      foreach (n.t[i]) n.t[i] = tv;
      foreach (n.q[i]) n.q[i] = qv;
      return n;
   endfunction

   // Present one item, wait for its acceptance, then insert a random gap at the end of a burst.
   task automatic send_node(input node_item_type n);
      req_tuser  = n.first;
      req_tdata  = {7'b0, n.t[2], n.t[1], n.t[0], n.q[3], n.q[2], n.q[1], n.q[0],
                    n.s[2], n.s[1], n.s[0], n.par};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (n.first) next_position = 0;
      if (next_position < 256) next_position++;
      sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid = 1'b0;
         req_tdata  = '0;
         repeat ($urandom_range(12)) @(negedge clock);
         burst_left = $urandom_range(30);
      end
   endtask

   initial begin
      node_item_type n;
      req_tvalid    = 1'b0;
      req_tuser     = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      reset         = 1'b1;
      next_position = 0;
      burst_left    = 0;
      sent          = 0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // Directed: identity root, chains, extremes and bad parents.
      n = plain_node(1, -1, 32'h0001_0000, 32'h0, 32'h0);
      n.q[3] = 32'h0001_0000;
      send_node(n);
      send_node(plain_node(0, 0, 32'h0002_0000, 32'h0000_8000, 32'h0003_0000));
      send_node(plain_node(0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_node(plain_node(0, 2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send_node(plain_node(0, -1, 32'h0, 32'h0, 32'h0));
      send_node(plain_node(0, 5, 32'hFFFF_0000, 32'h0000_B505, 32'hFFFF_FFFF));
      send_node(plain_node(0, 255, 32'h0001_0000, 32'h0, 32'h1234_5678));
      send_node(plain_node(0, -256, 32'h0001_8000, 32'hFFFF_8000, 32'h0));
      send_node(plain_node(0, -2, 32'h0001_0000, 32'h0000_4000, 32'h0001_0000));
      send_node(plain_node(0, 3, 32'h0001_0000, 32'h0000_8000, 32'h8000_0000));
      send_node(plain_node(0, 1, 32'h7FFF_FFFF, 32'h0001_0000, 32'h7FFF_FFFF));
      send_node(plain_node(1, 0, 32'h0001_0000, 32'h0000_8000, 32'h0000_0100));
      send_node(plain_node(0, 0, 32'h0000_8000, 32'hFFFF_8000, 32'hFFFF_0000));
      send_node(plain_node(0, 1, 32'h0003_0000, 32'h0000_2000, 32'h0000_0001));

      // Random passes of well-formed hierarchies with some broken parents.
      for (int i = 0; i < 116; i++)
         send_node(rand_node($urandom % 25 == 0, 10));

      req_tvalid = 1'b0;
      while (rows_pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);

      $display("Sent %0d nodes in directed and random passes, %0d of %0d checked nodes",
               sent, error_nodes, nodes_seen);
      $display("flagged with a bad parent; %0d mismatches.", fail_count);
      if (fail_count == 0 && rows_pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

### files.f
hw/rtl/hnt_pkg.sv
hw/rtl/hierarchical_node_transform_top.sv
verif/hnt_checker.sv
verif/testbench.sv
